@@ src/pnm_hdr_pkg.sv @@
// ----------------------------------------------------------------------------
// pnm_hdr_pkg
// Shared types and constants of the portable anymap header parser.
// ----------------------------------------------------------------------------
package pnm_hdr_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int STATUS_W   = 3;
    localparam int TYPE_W     = 3;
    localparam int FIELD_W    = 32;
    localparam int OUT_BITS   = STATUS_W + TYPE_W + 3 * FIELD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [TYPE_W-1:0] TYPE_BITMAP = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MAGIC    = 3'd1,
        ST_TYPE     = 3'd2,
        ST_MISSING  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [7:0] {
        PH_MAGIC = 8'b0000_0001,
        PH_TYPE  = 8'b0000_0010,
        PH_SEP_W = 8'b0000_0100,
        PH_NUM_W = 8'b0000_1000,
        PH_SEP_H = 8'b0001_0000,
        PH_NUM_H = 8'b0010_0000,
        PH_SEP_M = 8'b0100_0000,
        PH_NUM_M = 8'b1000_0000
    } t_phase;

endpackage

@@ src/pnm_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// pnm_header_parser_unit
// Byte-stream parser for portable anymap (P4/P5/P6) headers.
// ----------------------------------------------------------------------------
// Takes one header item per cycle, sustained. Each item is held in the
// input register; then the parser state and, when the item ends the header or
// hits an error, the result register are updated together from it, so a
// result passes the input register and then the result register. The only
// stall comes from a result that is held in the result register while the
// next item would produce another one. One result is given per header, then
// all items are dropped until an item with the restart flag.
module pnm_header_parser_unit #(
    parameter int VALUE_BITS = pnm_hdr_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] data_byte
    input  logic [pnm_hdr_pkg::IN_DATA_W-1:0] i_s_tdata,
    // [0] end_of_file, [1] restart
    input  logic [pnm_hdr_pkg::IN_USER_W-1:0] i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] status, [5:3] image_type, [37:6] width, [69:38] height,
    // [101:70] max_value, [103:102] zero
    output logic [pnm_hdr_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import pnm_hdr_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eof;
    logic                 r_in_restart;

    // parser state
    t_phase               r_phase,      n_phase;
    logic                 r_in_comment, n_in_comment;
    logic [VALUE_BITS-1:0] r_acc,       n_acc;
    logic [FIELD_W-1:0]   r_width,      n_width;
    logic [FIELD_W-1:0]   r_height,     n_height;
    logic [TYPE_W-1:0]    r_type,       n_type;
    logic                 r_finished,   n_finished;

    // result register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [TYPE_W-1:0]    r_out_type;
    logic [FIELD_W-1:0]   r_out_width;
    logic [FIELD_W-1:0]   r_out_height;
    logic [FIELD_W-1:0]   r_out_max;

    logic                 emit_c;
    t_status              emit_status;
    logic [FIELD_W-1:0]   emit_max;
    logic                 fire;
    logic                 in_accept;
    logic                 is_digit;
    logic                 is_space;
    logic [3:0]           digit;
    logic [VALUE_BITS+3:0] acc_x10;
    logic                 overflow;
    logic                 sep;

    assign is_digit = (r_in_byte >= CH_0) && (r_in_byte <= CH_9);
    assign is_space = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) ||
                      (r_in_byte == CH_LF);
    assign digit    = r_in_byte[3:0];

    // acc * 10 + digit, with four guard bits to catch overflow
    assign acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                      {{VALUE_BITS{1'b0}}, digit};
    assign overflow = |acc_x10[VALUE_BITS+3:VALUE_BITS];

    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_acc        = r_acc;
        n_width      = r_width;
        n_height     = r_height;
        n_type       = r_type;
        n_finished   = r_finished;
        emit_c       = 1'b0;
        emit_status  = ST_OK;
        emit_max     = '0;
        sep          = 1'b0;

        if (r_in_restart) begin
            n_phase      = PH_MAGIC;
            n_in_comment = 1'b0;
            n_acc        = '0;
            n_width      = '0;
            n_height     = '0;
            n_type       = '0;
            n_finished   = 1'b0;
        end

        if (!n_finished) begin
            unique case (n_phase)
                PH_MAGIC: begin
                    if (n_in_comment) begin
                        if (r_in_eof) begin
                            emit_c      = 1'b1;
                            emit_status = ST_MAGIC;
                        end else if (r_in_byte == CH_LF) begin
                            n_in_comment = 1'b0;
                        end
                    end else if (r_in_eof) begin
                        emit_c      = 1'b1;
                        emit_status = ST_MAGIC;
                    end else if (r_in_byte == CH_HASH) begin
                        n_in_comment = 1'b1;
                    end else if (r_in_byte == CH_P) begin
                        n_phase = PH_TYPE;
                    end else begin
                        emit_c      = 1'b1;
                        emit_status = ST_MAGIC;
                    end
                end
                PH_TYPE: begin
                    if (!r_in_eof && r_in_byte >= CH_4 && r_in_byte <= CH_6) begin
                        n_type  = r_in_byte[TYPE_W-1:0];
                        n_phase = PH_SEP_W;
                    end else begin
                        emit_c      = 1'b1;
                        emit_status = ST_TYPE;
                    end
                end
                PH_SEP_W, PH_SEP_H, PH_SEP_M: begin
                    sep = 1'b1;
                end
                PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
                    if (!r_in_eof && is_digit) begin
                        if (overflow) begin
                            emit_c      = 1'b1;
                            emit_status = ST_OVERFLOW;
                        end else begin
                            n_acc = acc_x10[VALUE_BITS-1:0];
                        end
                    end else if (n_phase == PH_NUM_W) begin
                        n_width = FIELD_W'(r_acc);
                        n_phase = PH_SEP_H;
                        sep     = 1'b1;
                    end else if (n_phase == PH_NUM_H) begin
                        n_height = FIELD_W'(r_acc);
                        if (n_type == TYPE_BITMAP) begin
                            emit_c = 1'b1;
                        end else begin
                            n_phase = PH_SEP_M;
                            sep     = 1'b1;
                        end
                    end else begin
                        emit_c   = 1'b1;
                        emit_max = FIELD_W'(r_acc);
                    end
                end
                default: begin
                    n_phase = PH_MAGIC;
                end
            endcase

            // separator handling; a number just ended leaves in_comment clear
            if (sep) begin
                if (r_in_eof) begin
                    emit_c      = 1'b1;
                    emit_status = ST_MISSING;
                end else if (n_in_comment) begin
                    if (r_in_byte == CH_LF) begin
                        n_in_comment = 1'b0;
                    end
                end else if (is_space) begin
                    n_in_comment = 1'b0;
                end else if (r_in_byte == CH_HASH) begin
                    n_in_comment = 1'b1;
                end else if (is_digit) begin
                    n_acc = {{(VALUE_BITS-4){1'b0}}, digit};
                    unique case (n_phase)
                        PH_SEP_W: n_phase = PH_NUM_W;
                        PH_SEP_H: n_phase = PH_NUM_H;
                        default:  n_phase = PH_NUM_M;
                    endcase
                end else begin
                    emit_c      = 1'b1;
                    emit_status = ST_MISSING;
                end
            end

            if (emit_c) begin
                n_finished = 1'b1;
            end
        end
    end

    // advance the held item unless its result would collide with a waiting one
    assign fire       = r_in_valid && (!emit_c || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte    <= i_s_tdata;
            r_in_eof     <= i_s_tuser[0];
            r_in_restart <= i_s_tuser[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_in_comment <= 1'b0;
            r_acc        <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_type       <= '0;
            r_finished   <= 1'b0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
            r_acc        <= n_acc;
            r_width      <= n_width;
            r_height     <= n_height;
            r_type       <= n_type;
            r_finished   <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit_c) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit_c) begin
            r_out_status <= emit_status;
            r_out_type   <= n_type;
            r_out_width  <= n_width;
            r_out_height <= n_height;
            r_out_max    <= emit_max;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, r_out_max, r_out_height,
                         r_out_width, r_out_type, r_out_status};

`ifndef SYNTHESIS
    a_silent_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_finished && !r_in_restart) |-> !emit_c)
        else $error("result produced after header already finished");

    a_result_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit_c) |=> (r_finished && r_out_valid))
        else $error("emitted result did not latch finished and output valid");

    a_bitmap_no_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK && r_out_type == TYPE_BITMAP)
        |-> (r_out_max == '0))
        else $error("bitmap header reported a nonzero maximum value");
`endif

endmodule

@@ bench/pnm_header_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnm_header_parser_unit_tb
// Streams portable anymap headers, well-formed and broken, into the parser
// with random gaps on both sides and two long output hold-offs. A local
// byte-level parser model predicts each result; results are checked field
// by field in arrival order.
// ----------------------------------------------------------------------------
module pnm_header_parser_unit_tb;
    import pnm_hdr_pkg::*;

    localparam int          N_ITEMS     = 1850;
    localparam int          STALL_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 12;
    localparam logic [63:0] NUM_LIMIT   = {64{1'b1}} >> (64 - VALUE_BITS_DEF);

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       rst;
    } t_hdr_item;

    typedef struct {
        t_status              status;
        logic [TYPE_W-1:0]    img_type;
        logic [FIELD_W-1:0]   width;
        logic [FIELD_W-1:0]   height;
        logic [FIELD_W-1:0]   max_value;
    } t_hdr_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [IN_USER_W-1:0]  i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    pnm_header_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_hdr_item   hdr_items_q[$];
    t_hdr_result hdr_results_q[$];
    bit          rst_pending;
    int          mismatches   = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;

    // ---- parser model state ----
    t_phase              p_phase;
    bit                  p_comment;
    logic [63:0]         p_acc;
    logic [FIELD_W-1:0]  p_width;
    logic [FIELD_W-1:0]  p_height;
    logic [TYPE_W-1:0]   p_type;
    bit                  p_done;

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic t_phase next_phase(t_phase ph);
        case (ph)
            PH_SEP_W: return PH_NUM_W;
            PH_NUM_W: return PH_SEP_H;
            PH_SEP_H: return PH_NUM_H;
            PH_NUM_H: return PH_SEP_M;
            PH_SEP_M: return PH_NUM_M;
            default:  return PH_MAGIC;
        endcase
    endfunction

    task automatic reset_parser();
        p_phase   = PH_MAGIC;
        p_comment = 0;
        p_acc     = '0;
        p_width   = '0;
        p_height  = '0;
        p_type    = '0;
        p_done    = 0;
    endtask

    task automatic note_result(t_status st, logic [FIELD_W-1:0] mv);
        t_hdr_result r;
        r.status    = st;
        r.img_type  = p_type;
        r.width     = p_width;
        r.height    = p_height;
        r.max_value = mv;
        hdr_results_q.push_back(r);
        p_done = 1;
    endtask

    task automatic step_separator(bit eof, logic [7:0] b);
        if (p_comment) begin
            if (eof)
                note_result(ST_MISSING, '0);
            else if (b == CH_LF)
                p_comment = 0;
        end else if (eof) begin
            note_result(ST_MISSING, '0);
        end else if (b == CH_HASH) begin
            p_comment = 1;
        end else if (is_digit(b)) begin
            p_acc   = 64'(b - CH_0);
            p_phase = next_phase(p_phase);
        end else if (b != CH_SPACE && b != CH_TAB && b != CH_LF) begin
            note_result(ST_MISSING, '0);
        end
    endtask

    task automatic parse_hdr_item(logic [7:0] b, bit eof, bit rst);
        logic [63:0] d;
        if (rst)
            reset_parser();
        if (!p_done) begin
            case (p_phase)
                PH_MAGIC: begin
                    if (p_comment) begin
                        if (eof)
                            note_result(ST_MAGIC, '0);
                        else if (b == CH_LF)
                            p_comment = 0;
                    end else if (eof) begin
                        note_result(ST_MAGIC, '0);
                    end else if (b == CH_HASH) begin
                        p_comment = 1;
                    end else if (b == CH_P) begin
                        p_phase = PH_TYPE;
                    end else begin
                        note_result(ST_MAGIC, '0);
                    end
                end
                PH_TYPE: begin
                    if (!eof && b >= CH_4 && b <= CH_6) begin
                        p_type  = TYPE_W'(b - CH_0);
                        p_phase = PH_SEP_W;
                    end else begin
                        note_result(ST_TYPE, '0);
                    end
                end
                PH_SEP_W, PH_SEP_H, PH_SEP_M:
                    step_separator(eof, b);
                PH_NUM_W, PH_NUM_H, PH_NUM_M: begin
                    if (!eof && is_digit(b)) begin
                        d = 64'(b - CH_0);
                        if (p_acc > (NUM_LIMIT - d) / 10)
                            note_result(ST_OVERFLOW, '0);
                        else
                            p_acc = p_acc * 10 + d;
                    end else if (p_phase == PH_NUM_W) begin
                        p_width = p_acc[FIELD_W-1:0];
                        p_phase = PH_SEP_H;
                        step_separator(eof, b);
                    end else if (p_phase == PH_NUM_H) begin
                        p_height = p_acc[FIELD_W-1:0];
                        if (p_type == TYPE_BITMAP) begin
                            note_result(ST_OK, '0);
                        end else begin
                            p_phase = PH_SEP_M;
                            step_separator(eof, b);
                        end
                    end else begin
                        note_result(ST_OK, p_acc[FIELD_W-1:0]);
                    end
                end
                default:
                    p_phase = PH_MAGIC;
            endcase
        end
    endtask

    // ---- stimulus building ----
    task automatic add_item(logic [7:0] b, bit eof);
        t_hdr_item it;
        it.data = b;
        it.eof  = eof;
        it.rst  = rst_pending;
        rst_pending = 0;
        hdr_items_q.push_back(it);
    endtask

    task automatic add_comment();
        logic [7:0] b;
        add_item(CH_HASH, 0);
        repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom);
            add_item((b == CH_LF) ? CH_HASH : b, 0);
        end
        add_item(CH_LF, 0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    task automatic add_sep(int min_n);
        repeat ($urandom_range(min_n, 3)) begin
            if ($urandom_range(0, 99) < 70)
                add_item(pick_space(), 0);
            else
                add_comment();
        end
    endtask

    task automatic add_number();
        logic [63:0] v;
        logic [7:0]  digits[$];
        int          r;
        r = $urandom_range(0, 99);
        if (r < 35)
            v = 64'($urandom_range(0, 99));
        else if (r < 55)
            v = 64'($urandom_range(0, 99999));
        else if (r < 70)
            v = {32'h0, $urandom};
        else if (r < 75)
            v = 64'd0;
        else if (r < 80)
            v = 64'hFFFF_FFFF;
        else if (r < 85)
            v = 64'hFFFF_FFFF - 64'($urandom_range(0, 9));
        else if (r < 90)
            v = 64'h1_0000_0000 + 64'($urandom_range(0, 9));
        else
            v = {$urandom, $urandom} | 64'h1_0000_0000;
        if (v == 0)
            digits.push_front(CH_0);
        while (v != 0) begin
            digits.push_front(CH_0 + 8'(v % 10));
            v = v / 10;
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) digits.push_front(CH_0);
        foreach (digits[i])
            add_item(digits[i], 0);
    endtask

    // One header; a fifth of them get one item corrupted and all but up to three of the items after it cut.
    task automatic add_header();
        int         start;
        int         k;
        int         keep;
        logic [7:0] tdig;
        logic [7:0] b;
        int         r;
        rst_pending = 1;
        start = hdr_items_q.size();
        if ($urandom_range(0, 4) == 0)
            add_comment();
        add_item(CH_P, 0);
        tdig = CH_4 + 8'($urandom_range(0, 2));
        add_item(tdig, 0);
        add_sep(0);
        add_number();
        add_sep(1);
        add_number();
        if (tdig != CH_4) begin
            add_sep(1);
            add_number();
        end
        r = $urandom_range(0, 99);
        b = 8'($urandom);
        if (r < 40)
            add_item(b, 1);
        else if (r < 75)
            add_item(pick_space(), 0);
        else if (r < 85)
            add_item(CH_HASH, 0);
        else
            add_item(is_digit(b) ? CH_SPACE : b, 0);
        if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(start, hdr_items_q.size() - 1);
            case ($urandom_range(0, 3))
                0, 1: begin
                    hdr_items_q[k].data = 8'($urandom);
                    hdr_items_q[k].eof  = 0;
                end
                2:       hdr_items_q[k].eof  = 1;
                default: hdr_items_q[k].data = CH_0 + 8'($urandom_range(0, 9));
            endcase
            keep = k + 1 + $urandom_range(0, 3);
            while (hdr_items_q.size() > keep)
                void'(hdr_items_q.pop_back());
        end
        // pixel bytes after the header, dropped by the parser once it has a result
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) add_item(8'($urandom), 1'($urandom));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---- driver ----
    bit        in_taken = 0;
    int        send_gap = 0;
    bit        send_burst = 0;
    t_hdr_item send_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!(i_s_tvalid && !in_taken)) begin
            if ($urandom_range(0, 99) == 0)
                send_burst = !send_burst;
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (hdr_items_q.size() > 0) begin
                send_item = hdr_items_q.pop_front();
                i_s_tdata  <= send_item.data;
                i_s_tuser  <= {send_item.rst, send_item.eof};
                i_s_tvalid <= 1'b1;
                send_gap   <= send_burst ? 0 : pick_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---- receiver ----
    int recv_gap   = 0;
    bit recv_burst = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 8 : 40)) begin
            // long hold-off: the parser backs up and stalls its input
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else if (recv_gap > 0) begin
            i_m_tready <= 1'b0;
            recv_gap   <= recv_gap - 1;
        end else begin
            if ($urandom_range(0, 99) == 0)
                recv_burst = !recv_burst;
            i_m_tready <= 1'b1;
            recv_gap   <= recv_burst ? 0 : pick_gap();
        end
    end

    // ---- monitor ----
    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    t_hdr_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen <= results_seen + 1;
                if (hdr_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_tdata);
                    mismatches++;
                end else begin
                    want = hdr_results_q.pop_front();
                    check_field("status", 32'(want.status), 32'(o_m_tdata[2:0]));
                    check_field("image_type", 32'(want.img_type), 32'(o_m_tdata[5:3]));
                    check_field("width", want.width, o_m_tdata[37:6]);
                    check_field("height", want.height, o_m_tdata[69:38]);
                    check_field("max_value", want.max_value, o_m_tdata[101:70]);
                end
            end
            in_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready)
                parse_hdr_item(i_s_tdata, i_s_tuser[0], i_s_tuser[1]);
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        reset_parser();

        // comment with 0xFF before the magic, width without separator, end of file
        rst_pending = 1;
        add_item(CH_HASH, 0);
        add_item(8'hFF, 0);
        add_item(CH_LF, 0);
        add_item(CH_P, 0);
        add_item(CH_4, 0);
        add_item(CH_0 + 8'd1, 0);
        add_item(CH_SPACE, 0);
        add_item(CH_0 + 8'd2, 0);
        add_item(8'hFF, 1);
        // dropped after the result
        add_item(8'h00, 0);
        // restart together with end of file
        rst_pending = 1;
        add_item(8'h00, 1);
        // end of file inside a comment before the magic
        rst_pending = 1;
        add_item(CH_HASH, 0);
        add_item(8'h00, 1);
        // bad type digit
        rst_pending = 1;
        add_item(CH_P, 0);
        add_item(CH_0 + 8'd7, 0);
        // width overflows on its tenth digit
        rst_pending = 1;
        add_item(CH_P, 0);
        add_item(CH_4 + 8'd1, 0);
        repeat (10) add_item(CH_9, 0);

        while (hdr_items_q.size() < N_ITEMS)
            add_header();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (hdr_items_q.size() > 0 || i_s_tvalid);
        do @(posedge i_clk); while (hdr_results_q.size() > 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && hdr_results_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
